/* hdl/bbsibg_pkg.sv */
// shared constants for the indexed blum blum shub bit generator
package bbsibg_pkg;

  localparam int SeedBits    = 31;
  localparam int CfgDataBits = 31;
  localparam int CfgIdxBits  = 2;

  localparam logic [CfgIdxBits-1:0] CFG_PRIME_P    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_PRIME_Q    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_START_SEED = 2'd2;

endpackage

/* hdl/bbs_indexed_bit_generator_core.sv */
// indexed blum blum shub bit generator core with one shared modular adder
//
//   channel   signals                          transfer
//   cfg       cfg_we_i cfg_idx_i cfg_data_i    write when cfg_we_i high, no wait
//   in        in_valid_i in_ready_o            bit_index_i, one item at a time
//   out       out_valid_o out_ready_i          random_bit_o, one per input item
//
// one modular add/compare/subtract unit runs euclid, the division for lambda and
// every modular multiply, one multiplier bit at a time; a small product unit
// forms lambda and p*q. each of the INDEX_BITS + 2*PRIME_BITS exponent bits
// takes at most two multiplies mod m. reset restores p = 7, q = 11, seed = 1.
// in_ready_o is high only while idle; a result may wait.
module bbs_indexed_bit_generator_core #(
  parameter int INDEX_BITS = 16,
  parameter int PRIME_BITS = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bbsibg_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bbsibg_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [INDEX_BITS-1:0]              bit_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               random_bit_o
);
  import bbsibg_pkg::*;

  localparam int LB  = 2 * PRIME_BITS;
  localparam int MW  = (LB > SeedBits) ? LB : SeedBits;
  localparam int EW  = (INDEX_BITS > LB) ? INDEX_BITS : LB;
  localparam int MCW = $clog2(MW + 1);
  localparam int ECW = $clog2(EW + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD,
    S_GCD_NEXT,
    S_MUL_DBL,
    S_MUL_ADD,
    S_LAMBDA,
    S_LAMBDA_CHK,
    S_BASE_SET,
    S_PW_BIT,
    S_PW_SQ,
    S_PW_MUL,
    S_PW_END,
    S_MODULUS,
    S_SEED,
    S_DONE
  } state_e;

  state_e                state_q, ret_q;
  logic                  phase_q;
  logic [PRIME_BITS-1:0] prime_p_q, prime_q_q;
  logic [SeedBits-1:0]   seed_q;
  logic [PRIME_BITS-1:0] ga_q, gb_q, quo_q;
  logic [LB-1:0]         acc_q, mx_q, mod_q, base_q, res_q;
  logic [MW-1:0]         my_q;
  logic [MCW-1:0]        mcnt_q;
  logic [EW-1:0]         exp_q;
  logic [ECW-1:0]        ecnt_q;
  logic                  qbit_q, started_q, cur_bit_q;
  logic                  out_valid_q, random_bit_q;

  logic [PRIME_BITS-1:0] a_w, b_w, mul_a_w, mul_b_w;
  logic [LB-1:0]         prod_w, addend_w, red_w, pw_w;
  logic [LB:0]           sum_w;
  logic                  ge_w;

  assign a_w = (prime_p_q == '0) ? '0 : prime_p_q - PRIME_BITS'(1);
  assign b_w = (prime_q_q == '0) ? '0 : prime_q_q - PRIME_BITS'(1);

  // shared modular adder, operands below mod_q
  assign addend_w = (state_q == S_MUL_ADD) ? mx_q : acc_q;
  assign sum_w    = {1'b0, acc_q} + {1'b0, addend_w};
  assign ge_w     = (sum_w >= {1'b0, mod_q});
  assign red_w    = ge_w ? LB'(sum_w - {1'b0, mod_q}) : sum_w[LB-1:0];

  // lambda = (a / g) * b, modulus = p * q
  assign mul_a_w = (state_q == S_LAMBDA) ? quo_q : prime_p_q;
  assign mul_b_w = (state_q == S_LAMBDA) ? b_w : prime_q_q;
  assign prod_w  = LB'(mul_a_w) * LB'(mul_b_w);

  assign pw_w = started_q ? res_q : LB'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      phase_q      <= 1'b0;
      prime_p_q    <= PRIME_BITS'(7);
      prime_q_q    <= PRIME_BITS'(11);
      seed_q       <= SeedBits'(1);
      ga_q         <= '0;
      gb_q         <= '0;
      quo_q        <= '0;
      acc_q        <= '0;
      mx_q         <= '0;
      mod_q        <= '0;
      base_q       <= '0;
      res_q        <= '0;
      my_q         <= '0;
      mcnt_q       <= '0;
      exp_q        <= '0;
      ecnt_q       <= '0;
      qbit_q       <= 1'b0;
      started_q    <= 1'b0;
      cur_bit_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      random_bit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRIME_P:    prime_p_q <= cfg_data_i[PRIME_BITS-1:0];
          CFG_PRIME_Q:    prime_q_q <= cfg_data_i[PRIME_BITS-1:0];
          CFG_START_SEED: seed_q    <= cfg_data_i[SeedBits-1:0];
          default: ;
        endcase
      end

      if (out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            exp_q  <= EW'(bit_index_i) << (EW - INDEX_BITS);
            ecnt_q <= ECW'(INDEX_BITS);
            if (a_w == '0 || b_w == '0) begin
              res_q   <= LB'(1);
              state_q <= S_DONE;
            end else begin
              ga_q    <= a_w;
              gb_q    <= b_w;
              state_q <= S_GCD;
            end
          end
        end

        S_GCD: begin
          acc_q   <= '0;
          mx_q    <= LB'(1);
          state_q <= S_MUL_DBL;
          mcnt_q  <= MCW'(PRIME_BITS);
          if (gb_q == '0) begin
            // gcd found, divide a by it
            my_q  <= MW'(a_w) << (MW - PRIME_BITS);
            mod_q <= LB'(ga_q);
            ret_q <= S_LAMBDA;
          end else begin
            my_q  <= MW'(ga_q) << (MW - PRIME_BITS);
            mod_q <= LB'(gb_q);
            ret_q <= S_GCD_NEXT;
          end
        end

        S_GCD_NEXT: begin
          ga_q    <= gb_q;
          gb_q    <= acc_q[PRIME_BITS-1:0];
          state_q <= S_GCD;
        end

        S_MUL_DBL: begin
          acc_q  <= red_w;
          qbit_q <= ge_w;
          if (my_q[MW-1]) begin
            state_q <= S_MUL_ADD;
          end else begin
            quo_q  <= {quo_q[PRIME_BITS-2:0], ge_w};
            my_q   <= my_q << 1;
            mcnt_q <= mcnt_q - MCW'(1);
            if (mcnt_q == MCW'(1)) begin
              state_q <= ret_q;
            end
          end
        end

        S_MUL_ADD: begin
          acc_q   <= red_w;
          quo_q   <= {quo_q[PRIME_BITS-2:0], qbit_q | ge_w};
          my_q    <= my_q << 1;
          mcnt_q  <= mcnt_q - MCW'(1);
          state_q <= (mcnt_q == MCW'(1)) ? ret_q : S_MUL_DBL;
        end

        S_LAMBDA: begin
          mod_q   <= prod_w;
          state_q <= S_LAMBDA_CHK;
        end

        S_LAMBDA_CHK: begin
          if (mod_q == LB'(1)) begin
            res_q   <= LB'(1);
            state_q <= S_DONE;
          end else begin
            // base 2 reduced mod lambda
            acc_q   <= '0;
            mx_q    <= LB'(1);
            my_q    <= MW'(2) << (MW - 2);
            mcnt_q  <= MCW'(2);
            phase_q <= 1'b0;
            ret_q   <= S_BASE_SET;
            state_q <= S_MUL_DBL;
          end
        end

        S_BASE_SET: begin
          base_q    <= acc_q;
          started_q <= 1'b0;
          state_q   <= S_PW_BIT;
        end

        S_PW_BIT: begin
          if (ecnt_q == '0) begin
            state_q <= S_PW_END;
          end else begin
            cur_bit_q <= exp_q[EW-1];
            exp_q     <= exp_q << 1;
            ecnt_q    <= ecnt_q - ECW'(1);
            if (!started_q) begin
              if (exp_q[EW-1]) begin
                res_q     <= base_q;
                started_q <= 1'b1;
              end
            end else begin
              acc_q   <= '0;
              mx_q    <= res_q;
              my_q    <= MW'(res_q) << (MW - LB);
              mcnt_q  <= MCW'(LB);
              ret_q   <= S_PW_SQ;
              state_q <= S_MUL_DBL;
            end
          end
        end

        S_PW_SQ: begin
          res_q <= acc_q;
          if (cur_bit_q) begin
            acc_q   <= '0;
            mx_q    <= base_q;
            my_q    <= MW'(acc_q) << (MW - LB);
            mcnt_q  <= MCW'(LB);
            ret_q   <= S_PW_MUL;
            state_q <= S_MUL_DBL;
          end else begin
            state_q <= S_PW_BIT;
          end
        end

        S_PW_MUL: begin
          res_q   <= acc_q;
          state_q <= S_PW_BIT;
        end

        S_PW_END: begin
          if (phase_q) begin
            res_q   <= pw_w;
            state_q <= S_DONE;
          end else if (pw_w == '0) begin
            res_q   <= LB'(1);
            state_q <= S_DONE;
          end else begin
            exp_q   <= EW'(pw_w) << (EW - LB);
            ecnt_q  <= ECW'(LB);
            state_q <= S_MODULUS;
          end
        end

        S_MODULUS: begin
          mod_q   <= prod_w;
          state_q <= S_SEED;
        end

        S_SEED: begin
          // seed reduced mod p*q
          acc_q   <= '0;
          mx_q    <= LB'(1);
          my_q    <= MW'(seed_q) << (MW - SeedBits);
          mcnt_q  <= MCW'(SeedBits);
          phase_q <= 1'b1;
          ret_q   <= S_BASE_SET;
          state_q <= S_MUL_DBL;
        end

        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            random_bit_q <= res_q[0];
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign random_bit_o = random_bit_q;

endmodule
